// ----- rtl/growable_slot_allocator_assert.svh -----
// assertion macros for the growable slot allocator checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef GROWABLE_SLOT_ALLOCATOR_ASSERT_SVH
`define GROWABLE_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define GSA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gsa assertion failed");

// next-cycle implication
`define GSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gsa assertion failed");

`endif

// ----- rtl/gsa_pkg.sv -----
// shared types and constants for the growable slot allocator
// no dependencies
`default_nettype none

package gsa_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam int INIT_CAP_DEF  = 16;
    localparam int WORD_W        = 32;
    localparam int BIT_W         = 5;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_QUERY = 2'd2,
        FN_CLAIM = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NOTUSED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_GROW,
        S_MOD
    } t_state;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bitpos;
    } t_find;

endpackage

`default_nettype wire

// ----- rtl/gsa_find_free.sv -----
// lowest free bit finder over one 32-bit word of the in-use bitmap
// depends on gsa_pkg
`default_nettype none

module gsa_find_free #(
    parameter int XW = 10
) (
    input  wire logic [gsa_pkg::WORD_W-1:0] i_used,
    input  wire logic [XW-1:0]              i_base,
    input  wire logic [XW-1:0]              i_cap,
    output gsa_pkg::t_find                  o_res
);
    import gsa_pkg::*;

    logic [XW-1:0]     rem;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] lowest;
    logic [BIT_W-1:0]  pos;

    // only bits below the capacity count as candidates
    always_comb begin
        rem = i_cap - i_base;
        if (i_cap <= i_base) begin
            mask = '0;
        end else if (rem >= XW'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
        end
    end

    assign free_bits = ~i_used & mask;
    assign lowest    = free_bits & (~free_bits + WORD_W'(1));

    // encode the isolated bit
    always_comb begin
        pos = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (lowest[b]) begin
                pos = pos | BIT_W'(b);
            end
        end
    end

    assign o_res.found  = |free_bits;
    assign o_res.bitpos = pos;

endmodule

`default_nettype wire

// ----- rtl/growable_slot_allocator.sv -----
// growable slot allocator: in-use bitmap, word scanner and capacity sequencer
// depends on gsa_pkg and gsa_find_free
`default_nettype none

// Usage
// Command channel: drive i_func and i_slot with start high while busy is low;
// that edge takes the beat. Operations: allocate the lowest free slot below
// the capacity (doubling the capacity when all are taken), free a slot, query
// a slot, or claim a named slot (doubling the capacity until it fits).
// Result channel: o_strobe is high for exactly one cycle with o_status,
// o_slot_out, o_replaced and o_capacity_now; the receiver cannot stall it,
// and a new command may be given in the strobe cycle.
// Sequence: a range error answers in the cycle after the command. Free and
// query take one bitmap read, then one check. Claim reads the target word,
// doubles the capacity once per grow step until the slot fits, then sets
// its bit. Allocate reads the bitmap one 32-bit word per cycle through a
// single scanner, up to ceil(capacity/32) words, plus a write step when
// the table grows. The bitmap is a word memory with one read and one write
// port.
// Reset: synchronous, active low. Afterwards a clearing pass writes zero to
// every bitmap word, one per cycle (ceil(MAX_SLOTS/32) words, 8 at the
// default size), with busy high; the capacity starts at INITIAL_CAPACITY
// clamped to 1..MAX_SLOTS.

module growable_slot_allocator #(
    parameter int MAX_SLOTS        = gsa_pkg::MAX_SLOTS_DEF,
    parameter int INITIAL_CAPACITY = gsa_pkg::INIT_CAP_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_func,
    input  wire logic [8:0] i_slot,
    output logic            o_strobe,
    output logic [1:0]      o_status,
    output logic [7:0]      o_slot_out,
    output logic            o_replaced,
    output logic [8:0]      o_capacity_now
);
    import gsa_pkg::*;

    // capacity clamped into 1..MAX_SLOTS
    localparam int INIT_CAP = (INITIAL_CAPACITY > MAX_SLOTS) ? MAX_SLOTS :
                              ((INITIAL_CAPACITY < 1) ? 1 : INITIAL_CAPACITY);
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIDX  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TW    = WIDX + BIT_W;
    localparam int XW0   = (CW > TW) ? CW : TW;
    // common compare width, wide enough for the doubled capacity and the slot port
    localparam int XW    = ((XW0 > 9) ? XW0 : 9) + 1;

    localparam logic [XW-1:0]   MAX_X     = XW'(MAX_SLOTS);
    localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORDS - 1);

    // bitmap memory, one bit per slot packed in 32-bit words
    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [TW-1:0]     r_tgt, n_tgt;
    logic [WIDX-1:0]   r_word, n_word;
    logic [CW-1:0]     r_cap, n_cap;
    logic              r_strobe, n_strobe;
    t_status           r_status, n_status;
    logic [7:0]        r_slot_out, n_slot_out;
    logic              r_replaced, n_replaced;

    logic              mem_we;
    logic [WIDX-1:0]   mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WIDX-1:0]   mem_raddr;

    logic              accept;
    t_func             in_func;
    logic [XW-1:0]     cap_x, tgt_x, slot_x, base_x, base_nx, cap2, cap_dbl;
    logic [WIDX-1:0]   word_nx;
    logic              scan_more, cap_full, grow_more, slot_bad, claim_bad;
    logic              tgt_bit;
    t_find             find;

    assign accept  = start && (r_state == S_IDLE);
    assign in_func = t_func'(i_func);

    assign cap_x   = XW'(r_cap);
    assign tgt_x   = XW'(r_tgt);
    assign slot_x  = XW'(i_slot);
    assign base_x  = XW'({r_word, {BIT_W{1'b0}}});
    assign base_nx = base_x + XW'(WORD_W);

    // shared doubler, clamped at the table size
    assign cap2    = cap_x << 1;
    assign cap_dbl = (cap2 > MAX_X) ? MAX_X : cap2;

    assign word_nx   = (r_word == LAST_WORD) ? r_word : r_word + WIDX'(1);
    assign scan_more = base_nx < cap_x;
    assign cap_full  = cap_x >= MAX_X;
    assign grow_more = (cap_x <= tgt_x) && !cap_full;
    assign slot_bad  = (slot_x >= cap_x) || (slot_x >= MAX_X);
    assign claim_bad = slot_x >= MAX_X;
    assign tgt_bit   = r_rdata[r_tgt[BIT_W-1:0]];

    gsa_find_free #(
        .XW (XW)
    ) u_find (
        .i_used (r_rdata),
        .i_base (base_x),
        .i_cap  (cap_x),
        .o_res  (find)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_word == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_func)
                        FN_ALLOC: n_state = S_SCAN;
                        FN_FREE,
                        FN_QUERY: n_state = slot_bad ? S_IDLE : S_MOD;
                        FN_CLAIM: n_state = claim_bad ? S_IDLE : S_GROW;
                    endcase
                end
            end
            S_SCAN: begin
                priority if (find.found) begin
                    n_state = S_IDLE;
                end else if (scan_more) begin
                    n_state = S_SCAN;
                end else if (cap_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_GROW: begin
                if (!grow_more) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_func     = r_func;
        n_tgt      = r_tgt;
        n_word     = r_word;
        n_cap      = r_cap;
        n_strobe   = 1'b0;
        n_status   = ST_OK;
        n_slot_out = '0;
        n_replaced = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_word;
        mem_wdata  = '0;
        mem_raddr  = '0;
        unique case (r_state)
            S_CLEAR: begin
                // zero one word per cycle
                mem_we = 1'b1;
                n_word = (r_word == LAST_WORD) ? '0 : r_word + WIDX'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_func = in_func;
                    n_tgt  = slot_x[TW-1:0];
                    n_word = '0;
                    unique case (in_func)
                        FN_ALLOC: begin
                            mem_raddr = '0;
                        end
                        FN_FREE,
                        FN_QUERY: begin
                            if (slot_bad) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_raddr = slot_x[TW-1:BIT_W];
                            end
                        end
                        FN_CLAIM: begin
                            if (claim_bad) begin
                                n_strobe = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                mem_raddr = slot_x[TW-1:BIT_W];
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (find.found) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_word;
                    mem_wdata  = r_rdata | (WORD_W'(1) << find.bitpos);
                    n_strobe   = 1'b1;
                    n_slot_out = 8'({r_word, find.bitpos});
                end else if (scan_more) begin
                    // fetch the next word while this one is checked
                    n_word    = word_nx;
                    mem_raddr = word_nx;
                end else if (cap_full) begin
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                end else begin
                    // grow: the first slot of the new region is the old capacity
                    n_tgt     = cap_x[TW-1:0];
                    n_cap     = CW'(cap_dbl);
                    mem_raddr = cap_x[TW-1:BIT_W];
                end
            end
            S_GROW: begin
                mem_raddr = r_tgt[TW-1:BIT_W];
                if (grow_more) begin
                    n_cap = CW'(cap_dbl);
                end
            end
            S_MOD: begin
                n_strobe  = 1'b1;
                mem_waddr = r_tgt[TW-1:BIT_W];
                mem_wdata = r_rdata;
                mem_wdata[r_tgt[BIT_W-1:0]] = 1'b1;
                unique case (r_func)
                    FN_ALLOC: begin
                        mem_we     = 1'b1;
                        n_slot_out = tgt_x[7:0];
                    end
                    FN_FREE: begin
                        mem_wdata[r_tgt[BIT_W-1:0]] = 1'b0;
                        if (tgt_bit) begin
                            mem_we     = 1'b1;
                            n_slot_out = tgt_x[7:0];
                        end else begin
                            n_status = ST_NOTUSED;
                        end
                    end
                    FN_QUERY: begin
                        if (tgt_bit) begin
                            n_slot_out = tgt_x[7:0];
                        end else begin
                            n_status = ST_NOTUSED;
                        end
                    end
                    FN_CLAIM: begin
                        mem_we     = 1'b1;
                        n_slot_out = tgt_x[7:0];
                        n_replaced = tgt_bit;
                    end
                endcase
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_word   <= '0;
            r_cap    <= CW'(INIT_CAP);
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_word   <= n_word;
            r_cap    <= n_cap;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_tgt      <= n_tgt;
        r_status   <= n_status;
        r_slot_out <= n_slot_out;
        r_replaced <= n_replaced;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_slot_out     = r_slot_out;
    assign o_replaced     = r_replaced;
    assign o_capacity_now = cap_x[8:0];

endmodule

`default_nettype wire

// ----- rtl/gsa_checker.sv -----
// port-level checker for the growable slot allocator, bound to the top level
// depends on gsa_pkg and growable_slot_allocator_assert.svh
`default_nettype none

`include "growable_slot_allocator_assert.svh"

module gsa_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       busy,
    input  wire logic       o_strobe,
    input  wire logic [1:0] o_status,
    input  wire logic [7:0] o_slot_out,
    input  wire logic       o_replaced
);
    import gsa_pkg::*;

    // a taken beat either starts work or answers at once
    `GSA_ASSERT_NEXT(a_accept_moves, start && !busy, busy || o_strobe)
    // results are shown only when the sequencer is back at rest
    `GSA_ASSERT_IMPL(a_strobe_idle, o_strobe, !busy)
    // failed operations report no slot
    `GSA_ASSERT_IMPL(a_fail_zero, o_strobe && (o_status != ST_OK),
                     (o_slot_out == 8'd0) && !o_replaced)
    // replacement is only reported on success
    `GSA_ASSERT_IMPL(a_repl_ok, o_strobe && o_replaced, o_status == ST_OK)

endmodule

bind growable_slot_allocator gsa_checker u_gsa_checker (.*);

`default_nettype wire
